### design/ghost_column_renumber_defines.svh
// ----------------------------------------------------------------------------
// ghost_column_renumber_defines: assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GHOST_COLUMN_RENUMBER_DEFINES_SVH
`define GHOST_COLUMN_RENUMBER_DEFINES_SVH
`ifndef SYNTHESIS
`define GCR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GCR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define GCR_ASSERT(lbl, clk, rst_n, prop, msg)
`define GCR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

### design/gcr_pkg.sv
// ----------------------------------------------------------------------------
// gcr_pkg
// Shared widths, request/error/register codes and table port struct.
// ----------------------------------------------------------------------------
`default_nettype none
package gcr_pkg;
	localparam int COL_W  = 16;
	localparam int CNT_W  = 17;
	localparam int RANK_W = 9;

	localparam logic [2:0] REQ_CLEAR = 3'd0;
	localparam logic [2:0] REQ_MARK  = 3'd1;
	localparam logic [2:0] REQ_BUILD = 3'd2;
	localparam logic [2:0] REQ_TRANS = 3'd3;
	localparam logic [2:0] REQ_READ  = 3'd4;

	localparam logic [1:0] ERR_OK        = 2'd0;
	localparam logic [1:0] ERR_NOT_FOUND = 2'd1;
	localparam logic [1:0] ERR_RANGE     = 2'd2;

	localparam logic [1:0] REG_NUM_RANKS  = 2'd0;
	localparam logic [1:0] REG_MY_RANK    = 2'd1;
	localparam logic [1:0] REG_LOCAL_COLS = 2'd2;

	typedef struct packed {
		logic             mk_we;
		logic [COL_W-1:0] mk_wa;
		logic             mk_wd;
		logic             mk_re;
		logic [COL_W-1:0] mk_ra;
		logic             sl_we;
		logic [COL_W-1:0] sl_wa;
		logic [COL_W-1:0] sl_wd;
		logic             sl_re;
		logic [COL_W-1:0] sl_ra;
		logic             gl_we;
		logic [COL_W-1:0] gl_wa;
		logic [COL_W-1:0] gl_wd;
		logic             gl_re;
		logic [COL_W-1:0] gl_ra;
	} tbl_ctl_t;
endpackage
`default_nettype wire

### design/gcr_divider.sv
// ----------------------------------------------------------------------------
// gcr_divider
// Restoring divider, one quotient bit per cycle: column by rank count.
// ----------------------------------------------------------------------------
`default_nettype none
module gcr_divider import gcr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [COL_W-1:0]  dividend,
	input  wire logic [RANK_W-1:0] divisor,
	output logic                   busy,
	output logic                   done,
	output logic [COL_W-1:0]       quo,
	output logic [RANK_W-1:0]      rem
);
	logic [4:0]        bit_q;
	logic [COL_W-1:0]  num_q;
	logic [RANK_W:0]   rem_q;
	logic [RANK_W-1:0] den_q;
	logic [RANK_W:0]   trial;
	logic [RANK_W:0]   diff;

	assign trial = {rem_q[RANK_W-1:0], num_q[COL_W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			done  <= 1'b0;
			bit_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy  <= 1'b1;
				bit_q <= 5'(COL_W);
			end else if (busy) begin
				bit_q <= bit_q - 5'd1;
				if (bit_q == 5'd1) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy) begin
			// shift the quotient bit in where the dividend bit leaves
			if (!diff[RANK_W]) begin
				rem_q <= diff;
				num_q <= {num_q[COL_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[COL_W-2:0], 1'b0};
			end
		end
	end

	assign quo = num_q;
	assign rem = rem_q[RANK_W-1:0];
endmodule
`default_nettype wire

### design/gcr_tables.sv
// ----------------------------------------------------------------------------
// gcr_tables
// Mark bitmap, column-to-slot map and ghost list memories.
// ----------------------------------------------------------------------------
`default_nettype none
module gcr_tables import gcr_pkg::*; #(
	parameter int MAX_COLS = 65536
) (
	input  wire logic             clk,
	input  wire tbl_ctl_t         ctl,
	output logic                  mk_rd,
	output logic [COL_W-1:0]      sl_rd,
	output logic [COL_W-1:0]      gl_rd
);
	localparam int SCAN = (MAX_COLS < 65536) ? MAX_COLS : 65536;
	localparam int AW   = (SCAN > 2) ? $clog2(SCAN) : 1;

	logic             mk_mem [SCAN];
	logic [COL_W-1:0] sl_mem [SCAN];
	logic [COL_W-1:0] gl_mem [65536];

	always_ff @(posedge clk) begin
		if (ctl.mk_we)
			mk_mem[ctl.mk_wa[AW-1:0]] <= ctl.mk_wd;
		if (ctl.mk_re)
			mk_rd <= mk_mem[ctl.mk_ra[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ctl.sl_we)
			sl_mem[ctl.sl_wa[AW-1:0]] <= ctl.sl_wd;
		if (ctl.sl_re)
			sl_rd <= sl_mem[ctl.sl_ra[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ctl.gl_we)
			gl_mem[ctl.gl_wa] <= ctl.gl_wd;
		if (ctl.gl_re)
			gl_rd <= gl_mem[ctl.gl_ra];
	end
endmodule
`default_nettype wire

### design/ghost_column_renumber.sv
// ----------------------------------------------------------------------------
// ghost_column_renumber
// Ghost column detection and renumbering for a cyclic column distribution.
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   req_type, column, ghost_slot
// out      output     out_valid/out_stall local_column, ghost_total, ghost_column, error
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// Mark and unknown requests go straight to the response state, read passes a
// table-read state and translate waits on the 16-step divider. Build walks
// the bitmap with a read and an evaluate state per column; clear sweeps it at
// one column a cycle. After reset a clearing pass runs before the first item
// is taken. A stalled result holds the block until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ghost_column_renumber_defines.svh"
module ghost_column_renumber import gcr_pkg::*; #(
	parameter int MAX_COLS = 65536
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        req_type,
	input  wire logic [COL_W-1:0]  column,
	input  wire logic [COL_W-1:0]  ghost_slot,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [CNT_W-1:0]       local_column,
	output logic [CNT_W-1:0]       ghost_total,
	output logic [COL_W-1:0]       ghost_column,
	output logic [1:0]             error,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [CNT_W-1:0]  cfg_data
);
	localparam int SCAN = (MAX_COLS < 65536) ? MAX_COLS : 65536;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CLR  = 3'd1;
	localparam logic [2:0] S_WRD  = 3'd2;
	localparam logic [2:0] S_WEV  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_LAT  = 3'd5;
	localparam logic [2:0] S_RESP = 3'd6;

	logic [2:0]        state_q;
	logic [COL_W-1:0]  cnt_q;
	logic              clr_rsp_q;
	logic [CNT_W-1:0]  n_q;
	logic [RANK_W-1:0] res_q;
	logic [CNT_W-1:0]  ghosts_q;
	logic              built_q;
	logic [RANK_W-1:0] num_ranks_q;
	logic [7:0]        my_rank_q;
	logic [CNT_W-1:0]  local_cols_q;
	logic [COL_W-1:0]  col_q;
	logic [COL_W-1:0]  slot_q;
	logic [CNT_W-1:0]  lcol_q;
	logic [COL_W-1:0]  gcol_q;
	logic [1:0]        err_q;
	logic              out_valid_q;
	logic [CNT_W-1:0]  out_lcol_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic [COL_W-1:0]  out_gcol_q;
	logic [1:0]        out_err_q;

	logic              accept;
	logic [RANK_W-1:0] rank_cnt;
	logic              scan_last;
	logic              hit;
	logic              out_free;
	tbl_ctl_t          ctl;
	logic              mk_rd;
	logic [COL_W-1:0]  sl_rd;
	logic [COL_W-1:0]  gl_rd;
	logic              div_busy;
	logic              div_done;
	logic [COL_W-1:0]  div_quo;
	logic [RANK_W-1:0] div_rem;

	function automatic logic in_scan(input logic [COL_W-1:0] c);
		return {1'b0, c} < CNT_W'(SCAN);
	endfunction

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign rank_cnt  = (num_ranks_q == '0) ? RANK_W'(1) : num_ranks_q;
	assign scan_last = (cnt_q == COL_W'(SCAN - 1));
	assign hit       = mk_rd && (res_q != {1'b0, my_rank_q}) && !n_q[CNT_W-1];
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		ctl       = '0;
		ctl.mk_ra = column;
		ctl.sl_ra = column;
		ctl.gl_ra = ghost_slot;
		ctl.mk_wa = column;
		ctl.mk_wd = 1'b1;
		ctl.sl_wa = cnt_q;
		ctl.sl_wd = n_q[COL_W-1:0];
		ctl.gl_wa = n_q[COL_W-1:0];
		ctl.gl_wd = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					ctl.mk_we = (req_type == REQ_MARK) && in_scan(column);
					ctl.mk_re = (req_type == REQ_TRANS);
					ctl.sl_re = (req_type == REQ_TRANS);
					ctl.gl_re = (req_type == REQ_READ);
				end
			end
			S_CLR: begin
				ctl.mk_we = 1'b1;
				ctl.mk_wa = cnt_q;
				ctl.mk_wd = 1'b0;
			end
			S_WRD: begin
				ctl.mk_re = 1'b1;
				ctl.mk_ra = cnt_q;
			end
			S_WEV: begin
				ctl.sl_we = hit;
				ctl.gl_we = hit;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			cnt_q        <= '0;
			clr_rsp_q    <= 1'b0;
			ghosts_q     <= '0;
			built_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			num_ranks_q  <= RANK_W'(1);
			my_rank_q    <= '0;
			local_cols_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_NUM_RANKS:  num_ranks_q  <= cfg_data[RANK_W-1:0];
					REG_MY_RANK:    my_rank_q    <= cfg_data[7:0];
					REG_LOCAL_COLS: local_cols_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_RESP && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req_type)
							REQ_CLEAR: begin
								cnt_q     <= '0;
								clr_rsp_q <= 1'b1;
								ghosts_q  <= '0;
								built_q   <= 1'b0;
								state_q   <= S_CLR;
							end
							REQ_MARK: begin
								if (in_scan(column))
									built_q <= 1'b0;
								state_q <= S_RESP;
							end
							REQ_BUILD: begin
								cnt_q   <= '0;
								state_q <= S_WRD;
							end
							REQ_TRANS: state_q <= S_DIV;
							REQ_READ:  state_q <= S_LAT;
							default:   state_q <= S_RESP;
						endcase
					end
				end
				S_CLR: begin
					cnt_q <= cnt_q + COL_W'(1);
					if (scan_last) begin
						clr_rsp_q <= 1'b0;
						state_q   <= clr_rsp_q ? S_RESP : S_IDLE;
					end
				end
				S_WRD: state_q <= S_WEV;
				S_WEV: begin
					cnt_q <= cnt_q + COL_W'(1);
					if (scan_last) begin
						ghosts_q <= n_q + CNT_W'(hit);
						built_q  <= 1'b1;
						state_q  <= S_RESP;
					end else begin
						state_q <= S_WRD;
					end
				end
				S_DIV: begin
					if (div_done)
						state_q <= S_RESP;
				end
				S_LAT: state_q <= S_RESP;
				S_RESP: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// walk state and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			col_q  <= column;
			slot_q <= ghost_slot;
			lcol_q <= '0;
			gcol_q <= '0;
			err_q  <= ERR_OK;
			n_q    <= '0;
			res_q  <= '0;
		end
		if (state_q == S_WEV) begin
			if (hit)
				n_q <= n_q + CNT_W'(1);
			res_q <= (res_q == rank_cnt - RANK_W'(1)) ? '0 : res_q + RANK_W'(1);
		end
		if (state_q == S_LAT) begin
			if (built_q && ({1'b0, slot_q} < ghosts_q))
				gcol_q <= gl_rd;
			else
				err_q <= ERR_RANGE;
		end
		if (state_q == S_DIV && div_done) begin
			if (div_rem == {1'b0, my_rank_q})
				lcol_q <= {1'b0, div_quo};
			else if (!built_q)
				err_q <= ERR_RANGE;
			else if (in_scan(col_q) && mk_rd)
				lcol_q <= local_cols_q + {1'b0, sl_rd};
			else
				err_q <= ERR_NOT_FOUND;
		end
		if (state_q == S_RESP && out_free) begin
			out_lcol_q <= lcol_q;
			out_cnt_q  <= ghosts_q;
			out_gcol_q <= gcol_q;
			out_err_q  <= err_q;
		end
	end

	gcr_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && req_type == REQ_TRANS),
		.dividend (column),
		.divisor  (rank_cnt),
		.busy     (div_busy),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	gcr_tables #(.MAX_COLS(MAX_COLS)) u_tbl (
		.clk   (clk),
		.ctl   (ctl),
		.mk_rd (mk_rd),
		.sl_rd (sl_rd),
		.gl_rd (gl_rd)
	);

	assign out_valid    = out_valid_q;
	assign local_column = out_lcol_q;
	assign ghost_total  = out_cnt_q;
	assign ghost_column = out_gcol_q;
	assign error        = out_err_q;

	`GCR_ASSERT(a_div_live, clk, arst_n, (state_q == S_DIV) |-> (div_busy || div_done), "divider idle while waiting on it")
	`GCR_ASSERT(a_cnt_max, clk, arst_n, ghosts_q <= CNT_W'(SCAN), "ghost count beyond bitmap size")
	`GCR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid_q && out_stall, out_valid_q && $stable(out_lcol_q) && $stable(out_err_q), "stalled result dropped or changed")
	`GCR_ASSERT(a_done_once, clk, arst_n, div_done |-> !div_busy, "divider done while busy")
endmodule
`default_nettype wire
